// File: hw/rtl/u8e_pkg.sv
// ----------------------------------------------------------------------------
// u8e_pkg: shared types and constants for the UTF-8 code point encoder
// Holds the queue entry format and the range bounds used to classify code
// points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8e_pkg;

    localparam int unsigned CpWidth   = 21;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned MaxBytes  = 4;
    localparam int unsigned IdxWidth  = $clog2(MaxBytes);

    // queue between classifier and serializer
    localparam int unsigned QDepth    = 2;
    localparam int unsigned QPtrWidth = $clog2(QDepth);
    localparam int unsigned QCntWidth = $clog2(QDepth + 1);

    // range bounds
    localparam logic [CpWidth-1:0] CpOneByteEnd   = 21'h000080;
    localparam logic [CpWidth-1:0] CpTwoByteEnd   = 21'h000800;
    localparam logic [CpWidth-1:0] CpThreeByteEnd = 21'h010000;
    localparam logic [CpWidth-1:0] CpFourByteEnd  = 21'h110000;
    localparam logic [CpWidth-1:0] SurrogateLo    = 21'h00D800;
    localparam logic [CpWidth-1:0] SurrogateHi    = 21'h00DFFF;
    localparam logic [CpWidth-1:0] NoncharLo      = 21'h00FDD0;
    localparam logic [CpWidth-1:0] NoncharHi      = 21'h00FDEF;

    // lead and continuation prefixes
    localparam logic [ByteWidth-1:0] LeadTwo   = 8'hC0;
    localparam logic [ByteWidth-1:0] LeadThree = 8'hE0;
    localparam logic [ByteWidth-1:0] LeadFour  = 8'hF0;
    localparam logic [ByteWidth-1:0] ContMark  = 8'h80;

    // one classified code point: bytes from the lead byte, index of last byte
    typedef struct packed {
        logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
        logic [IdxWidth-1:0]                last_idx;
        logic                               err;
    } t_entry;

endpackage

// File: hw/rtl/u8e_front.sv
// ----------------------------------------------------------------------------
// u8e_front: input stage and classifier
// Takes code points, sorts them by encoded length, rejects invalid values and
// hands a fully formed byte group to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8e_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [u8e_pkg::CpWidth-1:0]  i_code_point,
    output logic                         o_push,
    output u8e_pkg::t_entry              o_entry,
    input  logic                         i_full
);
    import u8e_pkg::*;

    logic                 r_valid;
    t_entry               r_entry;
    t_entry               n_entry;
    logic                 accept;
    logic                 cont_hi_err;
    logic                 bmp_err;

    // noncharacter / surrogate checks
    assign bmp_err = ((i_code_point >= SurrogateLo) && (i_code_point <= SurrogateHi)) ||
                     ((i_code_point >= NoncharLo) && (i_code_point <= NoncharHi));
    assign cont_hi_err = (i_code_point[15:1] == 15'h7FFF);

    // classify and build the byte group
    always_comb begin
        n_entry          = '0;
        n_entry.last_idx = IdxWidth'(0);
        n_entry.err      = 1'b0;
        if (i_code_point < CpOneByteEnd) begin
            n_entry.bytes[0] = {1'b0, i_code_point[6:0]};
        end else if (i_code_point < CpTwoByteEnd) begin
            n_entry.bytes[0] = LeadTwo | {3'b000, i_code_point[10:6]};
            n_entry.bytes[1] = ContMark | {2'b00, i_code_point[5:0]};
            n_entry.last_idx = IdxWidth'(1);
        end else if (i_code_point < CpThreeByteEnd) begin
            if (bmp_err) begin
                n_entry.err = 1'b1;
            end else begin
                n_entry.bytes[0] = LeadThree | {4'b0000, i_code_point[15:12]};
                n_entry.bytes[1] = ContMark | {2'b00, i_code_point[11:6]};
                n_entry.bytes[2] = ContMark | {2'b00, i_code_point[5:0]};
                n_entry.last_idx = IdxWidth'(2);
            end
        end else if (i_code_point < CpFourByteEnd) begin
            if (cont_hi_err) begin
                n_entry.err = 1'b1;
            end else begin
                n_entry.bytes[0] = LeadFour | {5'b00000, i_code_point[20:18]};
                n_entry.bytes[1] = ContMark | {2'b00, i_code_point[17:12]};
                n_entry.bytes[2] = ContMark | {2'b00, i_code_point[11:6]};
                n_entry.bytes[3] = ContMark | {2'b00, i_code_point[5:0]};
                n_entry.last_idx = IdxWidth'(3);
            end
        end else begin
            n_entry.err = 1'b1;
        end
    end

    // holding register; frees up when the queue takes its contents
    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

// File: hw/rtl/u8e_fifo.sv
// ----------------------------------------------------------------------------
// u8e_fifo: short queue between classifier and serializer
// Two entries of classified byte groups so either side can stall alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8e_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8e_pkg::t_entry  i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output u8e_pkg::t_entry  o_head
);
    import u8e_pkg::*;

    t_entry                 r_mem [QDepth];
    logic [QPtrWidth-1:0]   r_wr_ptr;
    logic [QPtrWidth-1:0]   r_rd_ptr;
    logic [QCntWidth-1:0]   r_count;
    logic [QCntWidth-1:0]   n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QCntWidth'(QDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCntWidth'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCntWidth'(1);
        end
    end

    // pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPtrWidth'(QDepth - 1)) ? '0
                            : r_wr_ptr + QPtrWidth'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPtrWidth'(QDepth - 1)) ? '0
                            : r_rd_ptr + QPtrWidth'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCntWidth'(QDepth))
        else $error("queue occupancy out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCntWidth'(QDepth)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with occupancy");
`endif

endmodule

// File: hw/rtl/u8e_back.sv
// ----------------------------------------------------------------------------
// u8e_back: byte serializer
// Pops byte groups from the queue and sends one byte per transfer through an
// output register, flagging the last byte and error results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8e_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  u8e_pkg::t_entry                i_head,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [u8e_pkg::ByteWidth-1:0]  o_out_byte,
    output logic                           o_is_last,
    output logic                           o_error
);
    import u8e_pkg::*;

    t_entry                 r_cur;
    logic                   r_cur_valid;
    logic [IdxWidth-1:0]    r_idx;
    logic                   r_ovalid;
    logic [ByteWidth-1:0]   r_obyte;
    logic                   r_olast;
    logic                   r_oerr;
    logic                   adv;
    logic                   cur_last;
    logic                   emit;

    assign adv      = !r_ovalid || !i_stall;
    assign emit     = adv && r_cur_valid;
    assign cur_last = (r_idx == r_cur.last_idx);
    assign o_pop    = (!r_cur_valid || (emit && cur_last)) && !i_empty;

    // current group and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
        end else if (o_pop) begin
            r_cur_valid <= 1'b1;
            r_idx       <= '0;
        end else if (emit) begin
            if (cur_last) begin
                r_cur_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IdxWidth'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= r_cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= r_cur.bytes[r_idx];
            r_olast <= cur_last;
            r_oerr  <= r_cur.err;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_is_last  = r_olast;
    assign o_error    = r_oerr;

`ifndef NO_ASSERTIONS
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oerr) |-> (r_olast && r_obyte == '0))
        else $error("error result must be a single zero byte");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_idx <= r_cur.last_idx))
        else $error("byte index past end of group");

    a_group_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast && !i_stall) |=> r_ovalid)
        else $error("gap inside a multi-byte sequence");
`endif

endmodule

// File: hw/rtl/utf8_code_point_encoder.sv
// ----------------------------------------------------------------------------
// utf8_code_point_encoder: UTF-8 encoder, one code point in, bytes out
// Classifier front end, two-entry queue, and a byte serializer back end.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   input    | i_valid, o_stall, i_code_point           | in
//   output   | o_valid, i_stall, o_out_byte, o_is_last, | out
//            | o_error                                  |
//
// The serializer sends one byte per cycle while the output is not stalled and a
// byte group is waiting. A code point gives 1 to 4 output bytes: one per UTF-8
// byte, or one for an error result.
// Reset is synchronous, active low, and empties every stage.
// The queue lets input transfers continue while the output is stalled until
// the queue and the input register are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_code_point_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [u8e_pkg::CpWidth-1:0]    i_code_point,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [u8e_pkg::ByteWidth-1:0]  o_out_byte,
    output logic                           o_is_last,
    output logic                           o_error
);
    import u8e_pkg::*;

    logic    push;
    t_entry  push_entry;
    logic    q_full;
    logic    q_empty;
    logic    pop;
    t_entry  head;

    u8e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_code_point (i_code_point),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_full       (q_full)
    );

    u8e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    u8e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_is_last  (o_is_last),
        .o_error    (o_error)
    );

endmodule

// File: verif/utf8_encoder_checker.sv
// ----------------------------------------------------------------------------
// utf8_encoder_checker: scoreboard for the UTF-8 code point encoder
// Watches both channels. Each code point transfer is turned into the byte
// sequence it must produce. Each output transfer is compared against the
// oldest byte still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_encoder_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [u8e_pkg::CpWidth-1:0]    i_code_point,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [u8e_pkg::ByteWidth-1:0]  i_out_byte,
    input  logic                           i_is_last,
    input  logic                           i_error,
    output int                             o_fail_count,
    output int                             o_pending
);

    // one owed output byte, tagged with the code point it came from
    typedef struct {
        logic [u8e_pkg::CpWidth-1:0]   cp;
        logic [u8e_pkg::ByteWidth-1:0] data;
        logic                          last;
        logic                          err;
    } t_owed_byte;

    t_owed_byte owed_bytes[$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic owe_byte(input logic [20:0] cp, input logic [7:0] data,
                            input logic last, input logic err);
        t_owed_byte b;
        b.cp   = cp;
        b.data = data;
        b.last = last;
        b.err  = err;
        owed_bytes.push_back(b);
    endtask

    // UTF-8 encoding of one code point, rejected values give one error byte
    task automatic encode_utf8(input logic [20:0] cp);
        logic reject;
        reject = 1'b0;
        if (cp < 21'h000080) begin
            owe_byte(cp, {1'b0, cp[6:0]}, 1'b1, 1'b0);
        end else if (cp < 21'h000800) begin
            owe_byte(cp, {3'b110, cp[10:6]}, 1'b0, 1'b0);
            owe_byte(cp, {2'b10, cp[5:0]}, 1'b1, 1'b0);
        end else if (cp < 21'h010000) begin
            // surrogates and the BMP noncharacter block are rejected
            reject = (cp >= 21'h00D800 && cp <= 21'h00DFFF) ||
                     (cp >= 21'h00FDD0 && cp <= 21'h00FDEF);
            if (!reject) begin
                owe_byte(cp, {4'b1110, cp[15:12]}, 1'b0, 1'b0);
                owe_byte(cp, {2'b10, cp[11:6]}, 1'b0, 1'b0);
                owe_byte(cp, {2'b10, cp[5:0]}, 1'b1, 1'b0);
            end
        end else if (cp < 21'h110000) begin
            // xFFFE and xFFFF in every supplementary plane are rejected
            reject = (cp[15:1] == 15'h7FFF);
            if (!reject) begin
                owe_byte(cp, {5'b11110, cp[20:18]}, 1'b0, 1'b0);
                owe_byte(cp, {2'b10, cp[17:12]}, 1'b0, 1'b0);
                owe_byte(cp, {2'b10, cp[11:6]}, 1'b0, 1'b0);
                owe_byte(cp, {2'b10, cp[5:0]}, 1'b1, 1'b0);
            end
        end else begin
            reject = 1'b1;
        end
        if (reject) begin
            owe_byte(cp, 8'h00, 1'b1, 1'b1);
        end
    endtask

    // sample both channels at the edge where the transfer happens
    always @(posedge i_clk) begin
        t_owed_byte want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                encode_utf8(i_code_point);
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b error %0b",
                                              i_out_byte, i_is_last, i_error));
                end else begin
                    want = owed_bytes.pop_front();
                    if (i_out_byte !== want.data) begin
                        report_mismatch($sformatf("cp %06h: byte %02h, want %02h",
                                                  want.cp, i_out_byte, want.data));
                    end
                    if (i_is_last !== want.last) begin
                        report_mismatch($sformatf("cp %06h: last %0b, want %0b",
                                                  want.cp, i_is_last, want.last));
                    end
                    if (i_error !== want.err) begin
                        report_mismatch($sformatf("cp %06h: error %0b, want %0b",
                                                  want.cp, i_error, want.err));
                    end
                end
            end
        end
        o_pending <= owed_bytes.size();
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the UTF-8 code point encoder
// Drives code points at every range boundary and reject class, then random
// ones weighted across the classes, with random gaps on the input side and
// random stalls on the output side, a long output hold-off and a stretch
// without any idling. The checker predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CycleLimit = 400000;
    localparam int RandItems  = 300;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [u8e_pkg::CpWidth-1:0]    i_code_point = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [u8e_pkg::ByteWidth-1:0]  o_out_byte;
    logic                           o_is_last;
    logic                           o_error;

    int fail_count;
    int pending;
    int cycles = 0;
    bit hold_req = 1'b0;
    bit stall_quiet = 1'b0;

    utf8_code_point_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_code_point (i_code_point),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_is_last    (o_is_last),
        .o_error      (o_error)
    );

    utf8_encoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_code_point (i_code_point),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_is_last    (o_is_last),
        .i_error      (o_error),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // code point drawn across all encoding lengths and reject classes
    function automatic logic [20:0] random_code_point();
        logic [20:0] cp;
        case ($urandom_range(0, 9))
            0: cp = 21'($urandom_range(21'h000000, 21'h00007F));
            1: cp = 21'($urandom_range(21'h000080, 21'h0007FF));
            2: cp = 21'($urandom_range(21'h000800, 21'h00FFFF));
            3: cp = 21'($urandom_range(21'h00D800, 21'h00DFFF));
            4: cp = 21'($urandom_range(21'h00FDD0, 21'h00FDEF));
            5: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
            6: begin
                // plane-final noncharacter in planes 1 to 16
                cp = {5'($urandom_range(1, 16)), 15'h7FFF, 1'($urandom_range(0, 1))};
            end
            7: cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
            default: cp = 21'($urandom);
        endcase
        return cp;
    endfunction

    // offer one code point and hold it until the transfer
    task automatic send_code_point(input logic [20:0] cp);
        i_valid      <= 1'b1;
        i_code_point <= cp;
        do @(posedge i_clk); while (o_stall);
    endtask

    // optional input gap, then one transfer
    task automatic send_with_gap(input logic [20:0] cp);
        if (!stall_quiet && $urandom_range(0, 1) == 0) begin
            i_valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        send_code_point(cp);
    endtask

    // output side stalls
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                // long hold-off so the input side backs up
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (120) @(posedge i_clk);
            end else if (!stall_quiet && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat (gap_len()) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    end

    // stimulus
    initial begin
        logic [20:0] boundary_cps[$];
        boundary_cps = '{
            21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
            21'h00D7FF, 21'h00D800, 21'h00DFFF, 21'h00E000, 21'h00FDCF,
            21'h00FDD0, 21'h00FDEF, 21'h00FDF0, 21'h00FFFD, 21'h00FFFE,
            21'h00FFFF, 21'h010000, 21'h01FFFE, 21'h01FFFF, 21'h10FFFD,
            21'h10FFFE, 21'h10FFFF, 21'h110000, 21'h1FFFFF, 21'h0AAAAA
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // range boundaries and every reject class
        foreach (boundary_cps[k]) begin
            send_with_gap(boundary_cps[k]);
        end

        // sender waits for the output to drain completely
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // back-to-back offers against a held output
        hold_req = 1'b1;
        repeat (20) send_code_point(random_code_point());

        // no idling on either side
        stall_quiet = 1'b1;
        repeat (60) send_code_point(random_code_point());
        stall_quiet = 1'b0;

        repeat (RandItems) send_with_gap(random_code_point());
        i_valid <= 1'b0;

        // drain, then watch for stray output
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
